@@ sv/biquad_lowpass_xyz_markers_defines.svh @@
// Assertion macros for the per-marker biquad low-pass block
`ifndef BIQUAD_LOWPASS_XYZ_MARKERS_DEFINES_SVH
`define BIQUAD_LOWPASS_XYZ_MARKERS_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BQLP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bqlp: same-cycle check failed");
// next-cycle implication
`define BQLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bqlp: next-cycle check failed");
`else
`define BQLP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BQLP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ sv/bqlp_pkg.sv @@
// Types, constants and register codes shared by the biquad low-pass block
package bqlp_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int COEF_W     = 32;
   localparam int MARKER_W   = 4;
   localparam int AXES       = 3;
   localparam int PROD_W     = SAMPLE_W + COEF_W;
   localparam int ACC_W      = PROD_W + 3;
   localparam int FRAC_SHIFT = 30;
   localparam int CSR_IDX_W  = 3;
   localparam int DEF_MARKER_COUNT = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_B0 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_B1 = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_B2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_A1 = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_A2 = CSR_IDX_W'(4);

   // 5 Hz cutoff at 100 Hz, Butterworth
   localparam logic signed [COEF_W-1:0] RST_B0 = 32'sd21563956;
   localparam logic signed [COEF_W-1:0] RST_B1 = 32'sd43127912;
   localparam logic signed [COEF_W-1:0] RST_B2 = 32'sd21563956;
   localparam logic signed [COEF_W-1:0] RST_A1 = -32'sd1676130314;
   localparam logic signed [COEF_W-1:0] RST_A2 = 32'sd688646466;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_type;

   typedef struct packed {
      sample_type x1;
      sample_type x2;
      sample_type y1;
      sample_type y2;
   } hist_type;

   typedef struct packed {
      logic accept;
      logic s2_load;
      logic s3_load;
      logic wr_en;
      logic clr;
   } lane_ctl_type;

endpackage

@@ sv/bqlp_lane.sv @@
// One axis lane: history memory, five products, partial sums, round and saturate
module bqlp_lane #(
   parameter int MARKER_COUNT = bqlp_pkg::DEF_MARKER_COUNT,
   parameter int ADDR_W = (MARKER_COUNT > 1) ? $clog2(MARKER_COUNT) : 1
) (
   input  logic                   clock,
   input  bqlp_pkg::lane_ctl_type ctl,
   input  logic [ADDR_W-1:0]      rd_addr,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  bqlp_pkg::coef_type     coef,
   input  bqlp_pkg::sample_type   pos,
   output bqlp_pkg::sample_type   result
);
   import bqlp_pkg::*;

   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd1 <<< (FRAC_SHIFT - 1));
   localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'(64'sh7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] SAT_MIN  = -SAT_MAX - ACC_W'(64'sd1);

   hist_type mem [MARKER_COUNT];

   // stage 1
   sample_type x_s1_ff;
   hist_type   hist_s1_ff;
   // stage 2
   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff, q3_ff, q4_ff;
   logic signed [PROD_W-1:0] p0_in, p1_in, p2_in, q3_in, q4_in;
   sample_type x_s2_ff, x1_s2_ff, y1_s2_ff;
   // stage 3
   logic signed [ACC_W-1:0] pa_ff, pb_ff, pa_in, pb_in;
   sample_type x_s3_ff, x1_s3_ff, y1_s3_ff;

   logic signed [ACC_W-1:0] total;
   logic signed [ACC_W-1:0] scaled;
   hist_type                wr_data;

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         x_s1_ff    <= pos;
         hist_s1_ff <= mem[rd_addr];
      end
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_comb begin
      p0_in = coef.b0 * x_s1_ff;
      p1_in = coef.b1 * hist_s1_ff.x1;
      p2_in = coef.b2 * hist_s1_ff.x2;
      q3_in = coef.a1 * hist_s1_ff.y1;
      q4_in = coef.a2 * hist_s1_ff.y2;
   end

   always_ff @(posedge clock) begin
      if (ctl.s2_load) begin
         p0_ff    <= p0_in;
         p1_ff    <= p1_in;
         p2_ff    <= p2_in;
         q3_ff    <= q3_in;
         q4_ff    <= q4_in;
         x_s2_ff  <= x_s1_ff;
         x1_s2_ff <= hist_s1_ff.x1;
         y1_s2_ff <= hist_s1_ff.y1;
      end
   end

   always_comb begin
      pa_in = ACC_W'(p0_ff) + ACC_W'(p1_ff) + ACC_W'(p2_ff);
      pb_in = ACC_W'(q3_ff) + ACC_W'(q4_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.s3_load) begin
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
         x_s3_ff  <= x_s2_ff;
         x1_s3_ff <= x1_s2_ff;
         y1_s3_ff <= y1_s2_ff;
      end
   end

   // round half up, then clamp to 32 bits; also the history write-back word (zeros while clearing)
   always_comb begin
      total  = pa_ff - pb_ff + RND_HALF;
      scaled = total >>> FRAC_SHIFT;
      if (scaled > SAT_MAX) begin
         result = SAMPLE_W'(SAT_MAX);
      end else if (scaled < SAT_MIN) begin
         result = SAMPLE_W'(SAT_MIN);
      end else begin
         result = scaled[SAMPLE_W-1:0];
      end
      if (ctl.clr) begin
         wr_data = '0;
      end else begin
         wr_data = '{x1: x_s3_ff, x2: x1_s3_ff, y1: result, y2: y1_s3_ff};
      end
   end

endmodule

@@ sv/bqlp_merge.sv @@
// Output register: gathers the three lane results into one word
module bqlp_merge (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         wb,
   input  logic [bqlp_pkg::MARKER_W-1:0]                marker,
   input  logic                                         in_range,
   input  logic [bqlp_pkg::AXES-1:0][bqlp_pkg::SAMPLE_W-1:0] lane_res,
   input  logic                                         rsp_stall,
   output logic                                         rsp_valid,
   output logic [bqlp_pkg::MARKER_W-1:0]                rsp_out_marker,
   output bqlp_pkg::sample_type                         rsp_filt_x,
   output bqlp_pkg::sample_type                         rsp_filt_y,
   output bqlp_pkg::sample_type                         rsp_filt_z
);
   import bqlp_pkg::*;

   logic                valid_ff;
   logic [MARKER_W-1:0] marker_ff;
   sample_type          fx_ff, fy_ff, fz_ff;
   sample_type          fx_in, fy_in, fz_in;

   // out-of-range marker gives zeros
   always_comb begin
      fx_in = in_range ? sample_type'(lane_res[0]) : '0;
      fy_in = in_range ? sample_type'(lane_res[1]) : '0;
      fz_in = in_range ? sample_type'(lane_res[2]) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wb) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wb) begin
         marker_ff <= marker;
         fx_ff     <= fx_in;
         fy_ff     <= fy_in;
         fz_ff     <= fz_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_marker = marker_ff;
   assign rsp_filt_x     = fx_ff;
   assign rsp_filt_y     = fy_ff;
   assign rsp_filt_z     = fz_ff;

endmodule

@@ sv/biquad_lowpass_xyz_markers.sv @@
// Top level: per-marker direct form I biquad low-pass on x, y and z
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | marker_index, pos_x, pos_y, pos_z
//   rsp     | out       | rsp_valid / rsp_stall | out_marker, filt_x, filt_y, filt_z
//   csr     | in        | csr_write_en          | csr_index, csr_data
//
// Words pass stages 1, 2, 3 and the output register; one word per cycle for distinct
// markers while rsp_stall is low. A request for a marker in stage 1, 2 or 3 stalls
// until that word is written back from stage 3: the history read at accept must see
// the previous result. After reset a clearing pass zeroes the history; req_stall is high.
// rsp_stall holds the output register; earlier stages keep moving into empty slots.
`include "biquad_lowpass_xyz_markers_defines.svh"

module biquad_lowpass_xyz_markers #(
   parameter int MARKER_COUNT = bqlp_pkg::DEF_MARKER_COUNT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [bqlp_pkg::MARKER_W-1:0]      req_marker_index,
   input  bqlp_pkg::sample_type               req_pos_x,
   input  bqlp_pkg::sample_type               req_pos_y,
   input  bqlp_pkg::sample_type               req_pos_z,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bqlp_pkg::MARKER_W-1:0]      rsp_out_marker,
   output bqlp_pkg::sample_type               rsp_filt_x,
   output bqlp_pkg::sample_type               rsp_filt_y,
   output bqlp_pkg::sample_type               rsp_filt_z,
   input  logic                               csr_write_en,
   input  logic [bqlp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bqlp_pkg::COEF_W-1:0]        csr_data
);
   import bqlp_pkg::*;

   localparam int ADDR_W = (MARKER_COUNT > 1) ? $clog2(MARKER_COUNT) : 1;

   coef_type coef_ff, coef_in;

   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                s1_valid_in, s2_valid_in, s3_valid_in;
   logic                s1_inr_ff, s2_inr_ff, s3_inr_ff;
   logic [MARKER_W-1:0] s1_marker_ff, s2_marker_ff, s3_marker_ff;

   logic out_ready, wb, s3_ready, s2_ready, s1_ready;
   logic s3_load, s2_load, accept, req_inr, hazard;

   lane_ctl_type                     lane_ctl;
   logic [ADDR_W-1:0]                rd_addr, wr_addr;
   logic [AXES-1:0][SAMPLE_W-1:0]    pos_all;
   logic [AXES-1:0][SAMPLE_W-1:0]    lane_res;

   // coefficient registers
   always_comb begin
      coef_in = coef_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_B0:  coef_in.b0 = csr_data;
            CSR_B1:  coef_in.b1 = csr_data;
            CSR_B2:  coef_in.b2 = csr_data;
            CSR_A1:  coef_in.a1 = csr_data;
            CSR_A2:  coef_in.a2 = csr_data;
            default: coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '{b0: RST_B0, b1: RST_B1, b2: RST_B2, a1: RST_A1, a2: RST_A2};
      end else begin
         coef_ff <= coef_in;
      end
   end

   // history clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(MARKER_COUNT - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // pipeline flow
   always_comb begin
      out_ready = !rsp_valid || !rsp_stall;
      wb        = s3_valid_ff && out_ready;
      s3_ready  = !s3_valid_ff || out_ready;
      s3_load   = s2_valid_ff && s3_ready;
      s2_ready  = !s2_valid_ff || s3_ready;
      s2_load   = s1_valid_ff && s2_ready;
      s1_ready  = !s1_valid_ff || s2_ready;
      req_inr   = 32'(req_marker_index) < MARKER_COUNT;
      hazard    = req_inr && (
                  (s1_valid_ff && s1_inr_ff && (s1_marker_ff == req_marker_index)) ||
                  (s2_valid_ff && s2_inr_ff && (s2_marker_ff == req_marker_index)) ||
                  (s3_valid_ff && s3_inr_ff && (s3_marker_ff == req_marker_index)));
      req_stall = clr_busy_ff || !s1_ready || hazard;
      accept    = req_valid && !req_stall;

      s1_valid_in = accept || (s1_valid_ff && !s2_load);
      s2_valid_in = s2_load || (s2_valid_ff && !s3_load);
      s3_valid_in = s3_load || (s3_valid_ff && !wb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_marker_ff <= req_marker_index;
         s1_inr_ff    <= req_inr;
      end
      if (s2_load) begin
         s2_marker_ff <= s1_marker_ff;
         s2_inr_ff    <= s1_inr_ff;
      end
      if (s3_load) begin
         s3_marker_ff <= s2_marker_ff;
         s3_inr_ff    <= s2_inr_ff;
      end
   end

   // lanes
   always_comb begin
      lane_ctl.accept  = accept;
      lane_ctl.s2_load = s2_load;
      lane_ctl.s3_load = s3_load;
      lane_ctl.clr     = clr_busy_ff;
      lane_ctl.wr_en   = clr_busy_ff || (wb && s3_inr_ff);
      rd_addr          = ADDR_W'(req_marker_index);
      wr_addr          = clr_busy_ff ? clr_addr_ff : ADDR_W'(s3_marker_ff);
      pos_all          = {req_pos_z, req_pos_y, req_pos_x};
   end

   for (genvar g = 0; g < AXES; g++) begin : g_lane
      bqlp_lane #(
         .MARKER_COUNT (MARKER_COUNT),
         .ADDR_W       (ADDR_W)
      ) u_lane (
         .clock   (clock),
         .ctl     (lane_ctl),
         .rd_addr (rd_addr),
         .wr_addr (wr_addr),
         .coef    (coef_ff),
         .pos     (sample_type'(pos_all[g])),
         .result  (lane_res[g])
      );
   end

   bqlp_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .wb             (wb),
      .marker         (s3_marker_ff),
      .in_range       (s3_inr_ff),
      .lane_res       (lane_res),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_out_marker (rsp_out_marker),
      .rsp_filt_x     (rsp_filt_x),
      .rsp_filt_y     (rsp_filt_y),
      .rsp_filt_z     (rsp_filt_z)
   );

   `BQLP_ASSERT_IMPL(a_no_same_marker, clock, reset, s2_valid_ff && s3_valid_ff && s2_inr_ff && s3_inr_ff, s2_marker_ff != s3_marker_ff)
   `BQLP_ASSERT_IMPL(a_clear_empty, clock, reset, clr_busy_ff, !(s1_valid_ff || s2_valid_ff || s3_valid_ff))
   `BQLP_ASSERT_NEXT(a_wb_shows, clock, reset, wb, rsp_valid)
   `BQLP_ASSERT_IMPL(a_oor_zero, clock, reset, rsp_valid && (32'(rsp_out_marker) >= MARKER_COUNT), (rsp_filt_x == '0) && (rsp_filt_y == '0) && (rsp_filt_z == '0))

endmodule

@@ tb/biquad_lowpass_xyz_markers_tb.sv @@
// Self-checking testbench for the per-marker xyz biquad low-pass filter
`timescale 1ns / 100ps

module biquad_lowpass_xyz_markers_tb;
   import bqlp_pkg::*;

   localparam int MARKERS     = DEF_MARKER_COUNT;
   localparam int HALF_PERIOD = 4;
   localparam int LATENCY     = 3;
   localparam int HOLD_CYCLES = 400;
   localparam int CSR_LAST    = (1 << CSR_IDX_W) - 1;

   localparam sample_type SAMPLE_MAX = 32'sh7fff_ffff;
   localparam sample_type SAMPLE_MIN = 32'sh8000_0000;
   localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7fff_ffff;
   localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;
   localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'sd1 <<< (FRAC_SHIFT - 1));

   typedef enum {COEF_STOCK, COEF_STABLE, COEF_WILD} coef_mode_type;

   typedef struct {
      logic [MARKER_W-1:0] marker;
      sample_type          fx;
      sample_type          fy;
      sample_type          fz;
   } filtered_word_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [MARKER_W-1:0]  req_marker_index;
   sample_type           req_pos_x;
   sample_type           req_pos_y;
   sample_type           req_pos_z;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [MARKER_W-1:0]  rsp_out_marker;
   sample_type           rsp_filt_x;
   sample_type           rsp_filt_y;
   sample_type           rsp_filt_z;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COEF_W-1:0]    csr_data;

   filtered_word_type filtered_due[$];
   int           in_flight [1 << MARKER_W];
   coef_type     coef_now;
   hist_type     hist [MARKERS][AXES];
   sample_type   track [MARKERS][AXES];

   int words_sent    = 0;
   int words_checked = 0;
   int mismatches    = 0;
   int csr_writes    = 0;
   int coef_sets     = 0;
   int clipped       = 0;
   int burst_left    = 1;
   int gap_max       = 2;
   int hold_ask      = 0;

   biquad_lowpass_xyz_markers dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_marker_index (req_marker_index),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_marker   (rsp_out_marker),
      .rsp_filt_x       (rsp_filt_x),
      .rsp_filt_y       (rsp_filt_y),
      .rsp_filt_z       (rsp_filt_z),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, msg);
   endfunction

   // y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2, exact sum, round half up, clip
   function automatic sample_type filter_axis(int m, int ax, sample_type xin);
      logic signed [COEF_W-1:0] b0, b1, b2, a1, a2;
      sample_type x1, x2, y1, y2, yout;
      logic signed [ACC_W-1:0] acc;
      b0 = coef_now.b0;
      b1 = coef_now.b1;
      b2 = coef_now.b2;
      a1 = coef_now.a1;
      a2 = coef_now.a2;
      x1 = hist[m][ax].x1;
      x2 = hist[m][ax].x2;
      y1 = hist[m][ax].y1;
      y2 = hist[m][ax].y2;
      acc = b0 * xin + b1 * x1 + b2 * x2 - a1 * y1 - a2 * y2;
      acc = (acc + HALF_LSB) >>> FRAC_SHIFT;
      if (acc > SAMPLE_MAX) begin
         yout = SAMPLE_MAX;
         clipped++;
      end else if (acc < SAMPLE_MIN) begin
         yout = SAMPLE_MIN;
         clipped++;
      end else begin
         yout = acc[SAMPLE_W-1:0];
      end
      hist[m][ax].x2 = x1;
      hist[m][ax].x1 = xin;
      hist[m][ax].y2 = y1;
      hist[m][ax].y1 = yout;
      return yout;
   endfunction

   function automatic filtered_word_type predict_word(int m, sample_type x, sample_type y,
                                                      sample_type z);
      filtered_word_type w;
      w.marker = MARKER_W'(m);
      if (m >= MARKERS) begin
         w.fx = '0;
         w.fy = '0;
         w.fz = '0;
      end else begin
         w.fx = filter_axis(m, 0, x);
         w.fy = filter_axis(m, 1, y);
         w.fz = filter_axis(m, 2, z);
      end
      return w;
   endfunction

   function automatic sample_type extreme_sample();
      case ($urandom_range(0, 4))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return '0;
         3: return -32'sd1;
         default: return 32'sd1;
      endcase
   endfunction

   // mostly slow marker tracks, some full-range noise and corners
   function automatic sample_type rand_sample(int m, int ax);
      case ($urandom_range(0, 9))
         0: return extreme_sample();
         1, 2: return sample_type'($urandom);
         default: begin
            track[m][ax] = track[m][ax] + $signed($urandom_range(0, 8192)) - 4096;
            return track[m][ax];
         end
      endcase
   endfunction

   function automatic coef_type random_coefs(coef_mode_type mode);
      coef_type c;
      int unsigned span;
      case (mode)
         COEF_STOCK: c = '{b0: RST_B0, b1: RST_B1, b2: RST_B2, a1: RST_A1, a2: RST_A2};
         COEF_STABLE: begin
            // poles inside the unit circle: a2 < 1, |a1| < 1 + a2
            c.a2 = $urandom_range(0, 900_000_000);
            span = (32'd1 << FRAC_SHIFT) + c.a2;
            c.a1 = -$signed($urandom_range(0, span - span / 16));
            c.b0 = $urandom_range(0, 1 << 28) - (1 << 27);
            c.b1 = $urandom_range(0, 1 << 28) - (1 << 27);
            c.b2 = $urandom_range(0, 1 << 28) - (1 << 27);
         end
         default: c = '{b0: $urandom, b1: $urandom, b2: $urandom, a1: $urandom,
                        a2: $urandom};
      endcase
      return c;
   endfunction

   function automatic int pick_marker();
      int m;
      m = 0;
      for (int t = 0; t < 64; t++) begin
         m = $urandom_range(0, MARKERS - 1);
         if (in_flight[m] == 0) return m;
      end
      return m;
   endfunction

   // one word per marker in flight; history must be written back first
   task automatic send_word(input int m, input sample_type x, input sample_type y,
                            input sample_type z);
      int gap;
      @(negedge clock);
      while (in_flight[m] != 0) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_marker_index = MARKER_W'(m);
      req_pos_x        = x;
      req_pos_y        = y;
      req_pos_z        = z;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      filtered_due.push_back(predict_word(m, x, y, z));
      in_flight[m]++;
      words_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         if (gap_max > 0) begin
            gap = $urandom_range(1, gap_max);
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic req_quiet();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic settle();
      req_quiet();
      while (filtered_due.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_data     = data;
      @(negedge clock);
      csr_write_en = 1'b0;
      case (idx)
         CSR_B0: coef_now.b0 = data;
         CSR_B1: coef_now.b1 = data;
         CSR_B2: coef_now.b2 = data;
         CSR_A1: coef_now.a1 = data;
         CSR_A2: coef_now.a2 = data;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic set_coefs(input coef_type c);
      csr_write(CSR_B0, c.b0);
      csr_write(CSR_B1, c.b1);
      csr_write(CSR_B2, c.b2);
      csr_write(CSR_A1, c.a1);
      csr_write(CSR_A2, c.a2);
      coef_sets++;
   endtask

   task automatic test_directed_defaults();
      repeat (6) send_word(0, SAMPLE_MAX, SAMPLE_MIN, '0);
      repeat (4) send_word(MARKERS - 1, SAMPLE_MIN, SAMPLE_MAX, -32'sd1);
      for (int m = 1; m < MARKERS - 1; m++)
         send_word(m, (m % 2) ? 32'sd1 : -32'sd1, (m % 2) ? -32'sd1 : 32'sd1, '0);
      settle();
   endtask

   task automatic test_coef_extremes();
      coef_type corner [4];
      int m;
      corner[0] = '{b0: COEF_MAX, b1: '0, b2: '0, a1: '0, a2: '0};
      corner[1] = '{b0: COEF_MIN, b1: COEF_MIN, b2: COEF_MIN, a1: COEF_MIN, a2: COEF_MIN};
      corner[2] = '{b0: COEF_MAX, b1: COEF_MAX, b2: COEF_MAX, a1: COEF_MAX, a2: COEF_MAX};
      corner[3] = '{b0: COEF_MIN, b1: COEF_MAX, b2: COEF_MIN, a1: COEF_MIN, a2: COEF_MAX};
      for (int i = 0; i < 4; i++) begin
         set_coefs(corner[i]);
         repeat (12) begin
            m = pick_marker();
            send_word(m, extreme_sample(), extreme_sample(), extreme_sample());
         end
         settle();
      end
   endtask

   // writes past the last coefficient must leave the filter untouched
   task automatic test_spare_registers();
      int m;
      set_coefs(random_coefs(COEF_STOCK));
      for (int i = int'(CSR_A2) + 1; i <= CSR_LAST; i++) begin
         csr_write(CSR_IDX_W'(i), $urandom);
         csr_write(CSR_IDX_W'(i), '1);
      end
      repeat (20) begin
         m = pick_marker();
         send_word(m, rand_sample(m, 0), rand_sample(m, 1), rand_sample(m, 2));
      end
      settle();
   endtask

   // output held off for a long stretch while the input keeps offering words
   task automatic test_backpressure();
      int m;
      gap_max    = 0;
      burst_left = 1000;
      hold_ask   = HOLD_CYCLES;
      repeat (60) begin
         m = pick_marker();
         send_word(m, rand_sample(m, 0), rand_sample(m, 1), rand_sample(m, 2));
      end
      settle();
   endtask

   task automatic test_random_stream();
      coef_mode_type mode;
      int m;
      for (int p = 0; p < 6; p++) begin
         mode = coef_mode_type'(p % 3);
         set_coefs(random_coefs(mode));
         case ($urandom_range(0, 3))
            0: gap_max = 0;
            1: gap_max = 1;
            2: gap_max = 3;
            default: gap_max = 8;
         endcase
         burst_left = 1;
         repeat (290) begin
            m = pick_marker();
            send_word(m, rand_sample(m, 0), rand_sample(m, 1), rand_sample(m, 2));
         end
         settle();
      end
   endtask

   // receiver: stall stretches of random density, plus a long hold on request
   initial begin : rsp_side
      int stretch, pct, held;
      rsp_stall = 1'b0;
      stretch   = 0;
      pct       = 0;
      held      = 0;
      forever begin
         @(negedge clock);
         if (hold_ask > 0) begin
            held     = hold_ask;
            hold_ask = 0;
         end
         if (held > 0) begin
            rsp_stall = 1'b1;
            held--;
         end else begin
            if (stretch == 0) begin
               stretch = $urandom_range(16, 200);
               case ($urandom_range(0, 5))
                  0, 1: pct = 0;
                  2: pct = 15;
                  3: pct = 40;
                  4: pct = 70;
                  default: pct = 90;
               endcase
            end
            stretch--;
            rsp_stall = ($urandom_range(0, 99) < pct);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      filtered_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (filtered_due.size() == 0) begin
            note_failure($sformatf("word with nothing expected: marker %0d x=%0d y=%0d z=%0d",
                                   rsp_out_marker, rsp_filt_x, rsp_filt_y, rsp_filt_z));
         end else begin
            want = filtered_due.pop_front();
            in_flight[want.marker]--;
            words_checked++;
            if (rsp_out_marker !== want.marker || rsp_filt_x !== want.fx ||
                rsp_filt_y !== want.fy || rsp_filt_z !== want.fz)
               note_failure($sformatf(
                  "word %0d: want m%0d %0d %0d %0d, got m%0d %0d %0d %0d",
                  words_checked, want.marker, want.fx, want.fy, want.fz,
                  rsp_out_marker, rsp_filt_x, rsp_filt_y, rsp_filt_z));
         end
      end
   end

   initial begin : run
      int leftover;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_marker_index = '0;
      req_pos_x        = '0;
      req_pos_y        = '0;
      req_pos_z        = '0;
      csr_write_en     = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      coef_now = '{b0: RST_B0, b1: RST_B1, b2: RST_B2, a1: RST_A1, a2: RST_A2};
      foreach (hist[i, j]) hist[i][j] = '0;
      foreach (in_flight[i]) in_flight[i] = 0;
      foreach (track[i, j])
         track[i][j] = sample_type'($urandom_range(0, 1 << 24)) - (1 << 23);
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_defaults();
      test_coef_extremes();
      test_spare_registers();
      test_backpressure();
      test_random_stream();

      req_quiet();
      for (int n = 0; n < 50_000 && filtered_due.size() != 0; n++) @(posedge clock);
      repeat (4 * LATENCY) @(posedge clock);
      leftover = filtered_due.size();
      if (leftover != 0) $display("%0d filtered words never arrived", leftover);
      $display("Ran %0d words over %0d coefficient sets (%0d register writes), %0d clipped.",
               words_sent, coef_sets, csr_writes, clipped);
      $display("Output held off %0d cycles in one stretch; %0d words checked, %0d errors.",
               HOLD_CYCLES, words_checked, mismatches);
      if (mismatches == 0 && leftover == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
